@@ design/gtpg_pkg.sv @@
// shared constants, types and helpers for the gradient test pattern generator
`default_nettype none

package gtpg_pkg;

  localparam int unsigned COL_W     = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned DEN_W     = 14;
  localparam int unsigned NUM_W     = 20;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned PHASE_W   = 6;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned IDX_W     = 1;
  localparam int unsigned IN_W      = 8;
  localparam int unsigned OUT_W     = 48;

  localparam logic [DIM_W-1:0] MAX_DIM      = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1280;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd720;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } div_sel_t;

  typedef struct packed {
    logic     take;
    logic     div_load;
    logic     div_step;
    logic     quot_store;
    logic     out_load;
    div_sel_t sel;
  } gtpg_cmd_t;

  typedef struct packed {
    logic out_free;
  } gtpg_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/gradient_test_pattern_generator.sv @@
// top level: animated rgb gradient test pattern source
// one request at a time: the next is accepted only after the last pixel is loaded
// into the output register; the single bit-serial divider is shared in turn
// by red, green and blue (20 steps plus load and store each)
// a result waiting in the output register does not block the next request
// rst (synchronous) clears position, frame count and handshake state and restores the reset frame size
`default_nettype none

module gradient_test_pattern_generator
  import gtpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // clear_frames
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // red, green, blue, column, row
  output logic                  m_tlast
);

  gtpg_cmd_t  cmd;
  gtpg_stat_t stat;

  gtpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtpg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_clear  (s_tdata[0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

@@ design/gtpg_ctrl.sv @@
// sequencer: request intake, shared divider passes per channel, result hand-off
`default_nettype none

module gtpg_ctrl
  import gtpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire gtpg_stat_t stat,
  output gtpg_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RUN,
    S_STORE,
    S_PUSH
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step_cnt;
  div_sel_t          sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      sel      <= SEL_RED;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sel   <= SEL_RED;
            state <= S_START;
          end
        end
        S_START: begin
          step_cnt <= '0;
          state    <= S_RUN;
        end
        S_RUN: begin
          step_cnt <= step_cnt + STEP_W'(1);
          if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          unique case (sel)
            SEL_RED: begin
              sel   <= SEL_GREEN;
              state <= S_START;
            end
            SEL_GREEN: begin
              sel   <= SEL_BLUE;
              state <= S_START;
            end
            default: begin
              state <= S_PUSH;
            end
          endcase
        end
        S_PUSH: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.sel        = sel;
    cmd.take       = (state == S_IDLE) && in_valid;
    cmd.div_load   = (state == S_START);
    cmd.div_step   = (state == S_RUN);
    cmd.quot_store = (state == S_STORE);
    cmd.out_load   = (state == S_PUSH) && stat.out_free;
  end

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && step_cnt == STEP_W'(DIV_STEPS - 1)) |=> state == S_STORE)
    else $error("divider pass did not end after its last step");

  a_store_after_step: assert property (@(posedge clk) disable iff (rst)
    cmd.quot_store |-> $past(cmd.div_step))
    else $error("quotient stored without a completed divider pass");

endmodule

`default_nettype wire

@@ design/gtpg_datapath.sv @@
// registers, position counters, shared bit-serial divider and output register
`default_nettype none

module gtpg_datapath
  import gtpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             in_clear,
  input  wire gtpg_cmd_t        cmd,
  output gtpg_stat_t            stat,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_last
);

  logic [DIM_W-1:0]   reg_width;
  logic [DIM_W-1:0]   reg_height;
  logic [DIM_W-1:0]   w;
  logic [DIM_W-1:0]   h;
  logic [COL_W-1:0]   col_count;
  logic [COL_W-1:0]   row_count;
  logic [PHASE_W-1:0] frame_phase_count;

  logic [COL_W-1:0]   x_cur;
  logic [COL_W-1:0]   y_cur;
  logic [PHASE_W-1:0] ph_cur;
  logic               line_end;
  logic               last_cur;

  logic [COL_W-1:0]   x_q;
  logic [COL_W-1:0]   y_q;
  logic [PHASE_W-1:0] phase_q;
  logic               last_q;

  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   den;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     diff;
  logic [DIM_W-1:0]   xy_sum;
  logic [PIX_W-1:0]   phase8;

  logic [PIX_W-1:0]   red_q;
  logic [PIX_W-1:0]   green_q;
  logic [PIX_W-1:0]   blue_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= RESET_WIDTH;
      reg_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  reg_width  <= cfg_data;
        REG_FRAME_HEIGHT: reg_height <= cfg_data;
      endcase
    end
  end

  assign w = clamp_dim(reg_width);
  assign h = clamp_dim(reg_height);

  // position of the incoming request
  assign x_cur    = in_clear ? '0 : col_count;
  assign y_cur    = in_clear ? '0 : row_count;
  assign ph_cur   = in_clear ? '0 : frame_phase_count;
  assign line_end = {1'b0, x_cur} >= (w - DIM_W'(1));
  assign last_cur = line_end && ({1'b0, y_cur} >= (h - DIM_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count         <= '0;
      row_count         <= '0;
      frame_phase_count <= '0;
    end else if (cmd.take) begin
      if (last_cur) begin
        col_count         <= '0;
        row_count         <= '0;
        frame_phase_count <= ph_cur + PHASE_W'(1);
      end else if (line_end) begin
        col_count         <= '0;
        row_count         <= y_cur + COL_W'(1);
        frame_phase_count <= ph_cur;
      end else begin
        col_count         <= x_cur + COL_W'(1);
        row_count         <= y_cur;
        frame_phase_count <= ph_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_q     <= x_cur;
      y_q     <= y_cur;
      phase_q <= ph_cur;
      last_q  <= last_cur;
    end
  end

  // restoring divider, one quotient bit per step
  assign xy_sum = {1'b0, x_q} + {1'b0, y_q};
  assign rem_sh = {rem, num[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      case (cmd.sel)
        SEL_RED: begin
          num <= {x_q, 8'b0} - {8'b0, x_q};
          den <= {1'b0, w};
        end
        SEL_GREEN: begin
          num <= {y_q, 8'b0} - {8'b0, y_q};
          den <= {1'b0, h};
        end
        default: begin
          num <= {xy_sum, 7'b0};
          den <= {1'b0, w} + {1'b0, h};
        end
      endcase
    end else if (cmd.div_step) begin
      rem <= diff[DEN_W] ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
      num <= {num[NUM_W-2:0], ~diff[DEN_W]};
    end
  end

  assign phase8 = {phase_q, 2'b00};

  always_ff @(posedge clk) begin
    if (cmd.quot_store) begin
      case (cmd.sel)
        SEL_RED:   red_q   <= phase8 + num[PIX_W-1:0];
        SEL_GREEN: green_q <= phase8 + num[PIX_W-1:0];
        default:   blue_q  <= phase8 + num[PIX_W-1:0];
      endcase
    end
  end

  // output register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {y_q, x_q, blue_q, green_q, red_q};
      out_last <= last_q;
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem < den)
    else $error("divider remainder not below divisor");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.take ##1 last_q |-> col_count == '0 && row_count == '0)
    else $error("position not back at origin after last pixel of frame");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the gradient test pattern generator: predicts every pixel and checks the stream
`default_nettype none

module tb_top
  import gtpg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] row;
    logic             last_of_frame;
  } pixel_t;

  class gradient_tracker;
    pixel_t           pending_pixels[$];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      frame_count;
    int               failures;

    function new();
      width_reg   = RESET_WIDTH;
      height_reg  = RESET_HEIGHT;
      col_pos     = 0;
      row_pos     = 0;
      frame_count = 0;
      failures    = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
    endfunction

    function int unsigned usable_dim(logic [DIM_W-1:0] v);
      int unsigned r;
      r = v;
      if (r < 1) r = 1;
      if (r > MAX_DIM) r = MAX_DIM;
      return r;
    endfunction

    function void note_request(bit clear);
      int unsigned w;
      int unsigned h;
      int unsigned phase;
      bit          line_end;
      pixel_t      p;
      w = usable_dim(width_reg);
      h = usable_dim(height_reg);
      if (clear) begin
        col_pos     = 0;
        row_pos     = 0;
        frame_count = 0;
      end
      phase    = (frame_count * 4) & 8'hFF;
      line_end = (col_pos >= w - 1);
      p.red           = PIX_W'(phase + (col_pos * 255) / w);
      p.green         = PIX_W'(phase + (row_pos * 255) / h);
      p.blue          = PIX_W'(phase + ((col_pos + row_pos) * 128) / (w + h));
      p.column        = COL_W'(col_pos);
      p.row           = COL_W'(row_pos);
      p.last_of_frame = line_end && (row_pos >= h - 1);
      pending_pixels.push_back(p);
      if (p.last_of_frame) begin
        col_pos     = 0;
        row_pos     = 0;
        frame_count = (frame_count + 1) & 6'h3F;
      end else if (line_end) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 16'hFFFF;
      end else begin
        col_pos = (col_pos + 1) & 16'hFFFF;
      end
    endfunction

    function void check_pixel(logic [OUT_W-1:0] data, logic last);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected pixel: data=%h last=%b", data, last);
        return;
      end
      e = pending_pixels.pop_front();
      if (data[7:0] !== e.red || data[15:8] !== e.green || data[23:16] !== e.blue ||
          data[35:24] !== e.column || data[47:36] !== e.row || last !== e.last_of_frame) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display({"pixel mismatch: exp r=%0d g=%0d b=%0d x=%0d y=%0d l=%b, ",
                    "got r=%0d g=%0d b=%0d x=%0d y=%0d l=%b"},
                   e.red, e.green, e.blue, e.column, e.row, e.last_of_frame,
                   data[7:0], data[15:8], data[23:16], data[35:24], data[47:36], last);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // clear_frames
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // red, green, blue, column, row
  logic             m_tlast;

  gradient_tracker tracker = new();
  bit              steady = 1'b0;
  int unsigned     cycles = 0;

  gradient_test_pattern_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver side with random back-pressure, none while steady is set
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_pixel(m_tdata, m_tlast);
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
  end

  task automatic send_pixel(input bit clear);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(clear);
    do @(posedge clk); while (!s_tready);
    tracker.note_request(clear);
    if (!steady && $urandom_range(99) < 30) begin
      gap = $urandom_range(1, 90);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every request has produced its pixel
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    tracker.write_reg(REG_FRAME_WIDTH, w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    tracker.write_reg(REG_FRAME_HEIGHT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned small_max);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return DIM_W'($urandom_range(1, small_max));
    if (k < 80) return DIM_W'($urandom_range(1, 64));
    if (k < 90) return DIM_W'($urandom);
    case ($urandom_range(3))
      0: return '0;
      1: return MAX_DIM;
      2: return '1;
      default: return DIM_W'(2);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned phase_no;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset dimensions, then a clear partway into the frame
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    // one-pixel frames advance the phase every pixel
    drain();
    write_dims(13'd1, 13'd1);
    repeat (4) send_pixel(1'b0);
    // zero dimensions are taken as one
    drain();
    write_dims('0, '0);
    repeat (2) send_pixel(1'b0);
    // oversize dimensions are taken as the maximum
    drain();
    write_dims('1, '1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    // width shrunk mid-line, then height shrunk mid-frame
    drain();
    write_dims(13'd8, 13'd3);
    send_pixel(1'b1);
    repeat (4) send_pixel(1'b0);
    drain();
    write_dims(13'd3, 13'd3);
    repeat (3) send_pixel(1'b0);
    drain();
    write_dims(13'd3, 13'd1);
    repeat (3) send_pixel(1'b0);

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      write_dims(pick_dim(8), pick_dim(6));
      steady  = (phase_no == 4);
      run_len = $urandom_range(15, 50);
      repeat (run_len) begin
        send_pixel($urandom_range(99) < 4);
        sent++;
        if ($urandom_range(199) == 0) drain();
      end
      steady = 1'b0;
      phase_no++;
    end

    drain();
    repeat (100) @(posedge clk);
    tracker.failures += tracker.pending_pixels.size();
    if (tracker.failures == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
